@@ rtl/gapf_pkg.sv @@
package gapf_pkg;

  localparam int MaxWidth  = 8;
  localparam int MaxHeight = 8;
  localparam int Cells     = MaxWidth * MaxHeight;
  localparam int CellW     = $clog2(Cells);
  localparam int XW        = 3;
  localparam int YW        = 3;
  localparam int CostW     = 17;
  localparam int FW        = 18;
  localparam int CntW      = CellW + 1;
  localparam int CfgW      = 4;

  localparam logic [CostW-1:0] CostStraight = 17'd1000;
  localparam logic [CostW-1:0] CostDiag     = 17'd1414;

  localparam logic [1:0] FuncSetWall   = 2'd0;
  localparam logic [1:0] FuncClearCell = 2'd1;
  localparam logic [1:0] FuncFindPath  = 2'd2;

  localparam logic CfgIdxWidth  = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  // datapath commands from the controller
  typedef struct packed {
    logic load;        // latch command word
    logic wall_wr;     // write wall map
    logic srch_init;   // clear marks, open start
    logic scan_clr;    // reset min scan
    logic scan_step;   // examine one cell
    logic pop;         // close the best cell
    logic nbr_step;    // relax one neighbour
    logic trace_init;  // begin back trace at goal
    logic trace_step;  // follow one parent pointer
    logic out_init;    // start emitting from the top of the buffer
    logic out_step;    // advance emit pointer
  } gapf_cmd_t;

  typedef struct packed {
    logic is_wall_cmd;
    logic is_search;
    logic in_grid;
    logic scan_done;
    logic have_best;
    logic best_is_goal;
    logic nbr_done;
    logic trace_done;
    logic out_last;
  } gapf_sts_t;

  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    unique case (d)
      3'd0, 3'd3, 3'd5: dir_dx = -2'sd1;
      3'd1, 3'd6:       dir_dx = 2'sd0;
      default:          dir_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    unique case (d)
      3'd0, 3'd1, 3'd2: dir_dy = -2'sd1;
      3'd3, 3'd4:       dir_dy = 2'sd0;
      default:          dir_dy = 2'sd1;
    endcase
  endfunction

endpackage

@@ rtl/gapf_datapath.sv @@
module gapf_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  input  logic [1:0]          func_i,
  input  logic [2:0]          cell_x_i,
  input  logic [2:0]          cell_y_i,
  input  logic [2:0]          goal_x_i,
  input  logic [2:0]          goal_y_i,
  input  gapf_pkg::gapf_cmd_t cmd_i,
  output gapf_pkg::gapf_sts_t sts_o,
  output logic [2:0]          step_x_o,
  output logic [2:0]          step_y_o
);
  import gapf_pkg::*;

  logic [CfgW-1:0] gw_q, gh_q;
  logic [XW:0] w_eff;
  logic [YW:0] h_eff;

  logic [1:0]  func_q;
  logic [XW-1:0] sx_q, gx_q;
  logic [YW-1:0] sy_q, gy_q;

  logic [Cells-1:0] wall_q, open_q, closed_q;
  logic [CostW-1:0] cost_mem [Cells];
  logic [2:0]       par_mem  [Cells];
  logic [CellW-1:0] buf_mem  [Cells];

  logic [CellW-1:0] scan_q;
  logic             scan_end_q;
  logic             scv_q;       // scan read in flight
  logic [CellW-1:0] scp_q;       // cell of that read
  logic [CostW-1:0] cost_rd_q;   // registered cost read
  logic [CellW-1:0] rd_addr;
  logic             scan_go;
  logic             sc_take;
  logic             best_v_q;
  logic [CellW-1:0] best_q;
  logic [FW-1:0]    bf_q;
  logic [CostW-1:0] bg_q;

  logic [3:0]       nd_q;
  logic             nv_q;        // neighbour relax pending
  logic [CellW-1:0] nc_q;
  logic [CostW-1:0] ng_q;
  logic [2:0]       npd_q;
  logic             n_free;
  logic             n_upd;

  logic [CellW-1:0] tc_q, tc_d;
  logic [2:0]       pd_q;
  logic [CellW-1:0] par_c;
  logic             trace_adv;
  logic [CntW-1:0]  n_q;
  logic             tr_done_q;
  logic [CntW-1:0]  op_q, op_d;
  logic [CellW-1:0] oc_q;

  always_comb begin
    w_eff = (gw_q == '0) ? (XW+1)'(1) : (gw_q > CfgW'(MaxWidth)) ? (XW+1)'(MaxWidth)
          : gw_q[XW:0];
    h_eff = (gh_q == '0) ? (YW+1)'(1) : (gh_q > CfgW'(MaxHeight)) ? (YW+1)'(MaxHeight)
          : gh_q[YW:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= CfgW'(MaxWidth);
      gh_q <= CfgW'(MaxHeight);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgIdxWidth) gw_q <= cfg_data_i;
      else                          gh_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      sx_q <= cell_x_i; sy_q <= cell_y_i;
      gx_q <= goal_x_i; gy_q <= goal_y_i;
    end
  end

  logic [CellW-1:0] start_c, goal_c;
  assign start_c = {sy_q, sx_q};
  assign goal_c  = {gy_q, gx_q};

  // scan: one cell read per cycle, compared in the cycle after, f = g + manhattan * 1000
  logic [XW-1:0] scx;
  logic [YW-1:0] scy;
  logic [XW-1:0] hdx;
  logic [YW-1:0] hdy;
  logic [XW:0]   hsum;
  logic [FW-1:0] f_c;
  logic          sc_in;
  assign scan_go = cmd_i.scan_step && !scan_end_q;
  assign scx = scp_q[XW-1:0];
  assign scy = scp_q[CellW-1:XW];
  assign hdx = (scx > gx_q) ? scx - gx_q : gx_q - scx;
  assign hdy = (scy > gy_q) ? scy - gy_q : gy_q - scy;
  assign hsum = {1'b0, hdx} + {1'b0, hdy};
  assign f_c = FW'(cost_rd_q) + FW'(hsum) * FW'(CostStraight);
  assign sc_in = ({1'b0, scx} < w_eff) && ({1'b0, scy} < h_eff) && open_q[scp_q];
  assign sc_take = scv_q && sc_in && (!best_v_q || f_c < bf_q);

  // neighbour of best cell
  logic [2:0]        nd;
  logic signed [4:0] nxs, nys;
  logic              n_ok, n_diag;
  logic [CellW-1:0]  nc;
  logic [CostW-1:0]  ng;
  assign nd   = nd_q[2:0];
  assign nxs  = $signed({2'b0, best_q[XW-1:0]}) + 5'(dir_dx(nd));
  assign nys  = $signed({2'b0, best_q[CellW-1:XW]}) + 5'(dir_dy(nd));
  assign n_ok = (nxs >= 0) && (nys >= 0) && (nxs < $signed({1'b0, w_eff}))
             && (nys < $signed({1'b0, h_eff}));
  assign nc   = {nys[YW-1:0], nxs[XW-1:0]};
  assign n_diag = (dir_dx(nd) != 0) && (dir_dy(nd) != 0);
  assign ng = bg_q + (n_diag ? CostDiag : CostStraight);
  assign n_free = n_ok && !wall_q[nc] && !closed_q[nc];
  // relax in the cycle after the cost read
  assign n_upd = nv_q && (!open_q[nc_q] || ng_q < cost_rd_q);

  // single cost read port, shared by scan and relax
  assign rd_addr = cmd_i.nbr_step ? nc : scan_q;

  // back trace
  logic signed [4:0] pxs, pys;
  logic              p_ok;
  assign pxs  = $signed({2'b0, tc_q[XW-1:0]}) - 5'(dir_dx(pd_q));
  assign pys  = $signed({2'b0, tc_q[CellW-1:XW]}) - 5'(dir_dy(pd_q));
  assign p_ok = (pxs >= 0) && (pys >= 0) && (pxs < $signed({1'b0, w_eff}))
             && (pys < $signed({1'b0, h_eff}));
  assign par_c = {pys[YW-1:0], pxs[XW-1:0]};
  assign trace_adv = cmd_i.trace_step && p_ok && !tr_done_q;

  always_comb begin
    tc_d = tc_q;
    if (cmd_i.trace_init)  tc_d = goal_c;
    else if (trace_adv)    tc_d = par_c;
  end

  always_comb begin
    op_d = op_q;
    if (cmd_i.out_init)      op_d = n_q - 1'b1;
    else if (cmd_i.out_step) op_d = op_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q <= '0; open_q <= '0; closed_q <= '0;
      scan_q <= '0; scan_end_q <= 1'b0; scv_q <= 1'b0; best_v_q <= 1'b0;
      nd_q <= '0; nv_q <= 1'b0; n_q <= '0; tr_done_q <= 1'b0; op_q <= '0;
    end else begin
      if (cmd_i.wall_wr && ({1'b0, sx_q} < w_eff) && ({1'b0, sy_q} < h_eff))
        wall_q[start_c] <= (func_q == FuncSetWall);
      if (cmd_i.srch_init) begin
        open_q <= Cells'(1) << start_c;
        closed_q <= '0;
      end
      if (cmd_i.scan_clr) begin
        scan_q <= '0; scan_end_q <= 1'b0; best_v_q <= 1'b0;
      end else begin
        if (scan_go) begin
          scan_q <= scan_q + 1'b1;
          if (scan_q == CellW'(Cells - 1)) scan_end_q <= 1'b1;
        end
        if (sc_take) best_v_q <= 1'b1;
      end
      scv_q <= scan_go;
      if (cmd_i.pop) begin
        open_q[best_q] <= 1'b0;
        if (best_q != goal_c) closed_q[best_q] <= 1'b1;
        nd_q <= '0;
      end
      if (cmd_i.nbr_step) nd_q <= nd_q + 1'b1;
      nv_q <= cmd_i.nbr_step && n_free;
      if (nv_q) open_q[nc_q] <= 1'b1;
      if (cmd_i.trace_init) begin
        n_q <= CntW'(1); tr_done_q <= (goal_c == start_c);
      end else if (cmd_i.trace_step) begin
        if (!p_ok) tr_done_q <= 1'b1;
        else begin
          n_q <= n_q + 1'b1;
          if (par_c == start_c || n_q + 1'b1 == CntW'(Cells))
            tr_done_q <= 1'b1;
        end
      end
      op_q <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cost_rd_q <= cost_mem[rd_addr];
    scp_q <= scan_q;
    nc_q <= nc; ng_q <= ng; npd_q <= nd;
    if (cmd_i.srch_init) cost_mem[start_c] <= '0;
    if (sc_take) begin
      best_q <= scp_q; bf_q <= f_c; bg_q <= cost_rd_q;
    end
    if (n_upd) begin
      cost_mem[nc_q] <= ng_q;
      par_mem[nc_q]  <= npd_q;
    end
    pd_q <= par_mem[tc_d];
    tc_q <= tc_d;
    if (cmd_i.trace_init) buf_mem[0] <= goal_c;
    else if (trace_adv)   buf_mem[n_q[CellW-1:0]] <= par_c;
    oc_q <= buf_mem[op_d[CellW-1:0]];
  end

  assign step_x_o = oc_q[XW-1:0];
  assign step_y_o = oc_q[CellW-1:XW];

  always_comb begin
    sts_o = '0;
    sts_o.is_wall_cmd = (func_q == FuncSetWall) || (func_q == FuncClearCell);
    sts_o.is_search   = (func_q == FuncFindPath);
    sts_o.in_grid     = ({1'b0, sx_q} < w_eff) && ({1'b0, sy_q} < h_eff)
                     && ({1'b0, gx_q} < w_eff) && ({1'b0, gy_q} < h_eff);
    sts_o.scan_done   = scan_end_q && !scv_q;
    sts_o.have_best   = best_v_q;
    sts_o.best_is_goal = (best_q == goal_c);
    sts_o.nbr_done    = nd_q[3];
    sts_o.trace_done  = tr_done_q;
    sts_o.out_last    = (op_q == '0);
  end

endmodule

@@ rtl/gapf_ctrl.sv @@
module gapf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic                last_o,
  input  gapf_pkg::gapf_sts_t sts_i,
  output gapf_pkg::gapf_cmd_t cmd_o
);
  import gapf_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StDec   = 9'b000000010,
    StScan  = 9'b000000100,
    StPick  = 9'b000001000,
    StNbr   = 9'b000010000,
    StTrace = 9'b000100000,
    StOut   = 9'b001000000,
    StNf    = 9'b010000000,
    StOInit = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    found_o = 1'b0;
    last_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = StDec;
        end
      end
      StDec: begin
        if (sts_i.is_wall_cmd) begin
          cmd_o.wall_wr = 1'b1;
          state_d = StIdle;
        end else if (!sts_i.is_search) state_d = StIdle;
        else if (!sts_i.in_grid) state_d = StNf;
        else begin
          cmd_o.srch_init = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_done) state_d = StPick;
        else cmd_o.scan_step = 1'b1;
      end
      StPick: begin
        if (!sts_i.have_best) state_d = StNf;
        else begin
          cmd_o.pop = 1'b1;
          if (sts_i.best_is_goal) begin
            cmd_o.trace_init = 1'b1;
            state_d = StTrace;
          end else state_d = StNbr;
        end
      end
      StNbr: begin
        if (sts_i.nbr_done) begin
          cmd_o.scan_clr = 1'b1;
          state_d = StScan;
        end else cmd_o.nbr_step = 1'b1;
      end
      StTrace: begin
        if (sts_i.trace_done) state_d = StOInit;
        else cmd_o.trace_step = 1'b1;
      end
      StOInit: begin
        cmd_o.out_init = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        found_o = 1'b1;
        last_o = sts_i.out_last;
        if (out_ready_i) begin
          cmd_o.out_step = 1'b1;
          if (sts_i.out_last) state_d = StIdle;
        end
      end
      StNf: begin
        out_valid_o = 1'b1;
        last_o = 1'b1;
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({cmd_o.scan_step, cmd_o.nbr_step, cmd_o.trace_step, cmd_o.out_step}) ||
    ({cmd_o.scan_step, cmd_o.nbr_step, cmd_o.trace_step, cmd_o.out_step} == '0))
    else $error("datapath commands overlap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> last_o)
    else $error("not-found word without last");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

@@ rtl/grid_astar_path_finder_top.sv @@
// 8-connected a* path finder on a grid of up to 8x8 cells. a command word either
// sets a wall, clears a cell or runs a search from (cell_x, cell_y) to
// (goal_x, goal_y); a search returns the path cells start to goal, last marked,
// or a single not-found word; other func codes are ignored. a search repeats a
// pipelined serial min-f scan over all cells, one pick and the relaxation of the
// eight neighbours for each expanded cell, then a back trace of one path cell
// per cycle and the emission of one word per cycle while the receiver is ready.
// the serial scan dominates the cost of a search. grid size registers are written
// through the cfg port; the user must write them only while idle, the block does not enforce it.
module grid_astar_path_finder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] func_i,
  input  logic [2:0] cell_x_i,
  input  logic [2:0] cell_y_i,
  input  logic [2:0] goal_x_i,
  input  logic [2:0] goal_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] step_x_o,
  output logic [2:0] step_y_o,
  output logic       found_o,
  output logic       last_o
);
  import gapf_pkg::*;

  gapf_cmd_t cmd;
  gapf_sts_t sts;
  logic [2:0] px, py;

  // controller sequences scan, expand, trace and emit
  gapf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .found_o, .last_o, .sts_i(sts), .cmd_o(cmd)
  );

  // datapath holds wall map, marks, costs, parents and path buffer
  gapf_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .func_i, .cell_x_i,
    .cell_y_i, .goal_x_i, .goal_y_i, .cmd_i(cmd), .sts_o(sts),
    .step_x_o(px), .step_y_o(py)
  );

  // not-found word reads as cell zero
  assign step_x_o = found_o ? px : 3'd0;
  assign step_y_o = found_o ? py : 3'd0;

endmodule

@@ bench/grid_astar_path_finder_top_test.sv @@
`timescale 1ns / 100ps

module grid_astar_path_finder_top_test;
  import gapf_pkg::*;

  localparam int SettleCycles = 200;
  localparam int LimitCycles  = 3000000;

  localparam logic [1:0] FuncUnused = 2'd3;

  // one command word for the finder
  typedef struct packed {
    logic [1:0] func;
    logic [2:0] cx;
    logic [2:0] cy;
    logic [2:0] gx;
    logic [2:0] gy;
  } cmd_word_t;

  // one emitted path word
  typedef struct packed {
    logic [2:0] sx;
    logic [2:0] sy;
    logic       found;
    logic       last;
  } step_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [3:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] func_i = '0;
  logic [2:0] cell_x_i = '0;
  logic [2:0] cell_y_i = '0;
  logic [2:0] goal_x_i = '0;
  logic [2:0] goal_y_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] step_x_o;
  logic [2:0] step_y_o;
  logic       found_o;
  logic       last_o;

  grid_astar_path_finder_top u_top (.*);

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [3:0]  width_reg, height_reg;
  logic        wall_q [Cells];
  logic        open_q [Cells];
  logic        shut_q [Cells];
  int unsigned cost_q [Cells];
  int          via_q  [Cells];

  cmd_word_t  pending_cmds [$];
  step_word_t path_due [$];
  int         mismatches = 0;
  longint     cycle_cnt = 0;

  // traffic shaping
  bit quiet_mode = 1'b0;   // no idling at all in the last part
  int hold_rx = 0;         // long receiver hold-off, in cycles
  bit tx_paused = 1'b0;
  bit in_taken = 1'b0;     // presented word accepted at the last rising edge
  int tx_gap = 0, rx_gap = 0;

  function automatic int clamp_dim(input logic [3:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic int step_dx(input int d);
    return (d == 0 || d == 3 || d == 5) ? -1 : (d == 1 || d == 6) ? 0 : 1;
  endfunction

  function automatic int step_dy(input int d);
    return (d <= 2) ? -1 : (d <= 4) ? 0 : 1;
  endfunction

  task automatic push_step(input int x, input int y, input bit f, input bit l);
    step_word_t s;
    s.sx = x[2:0]; s.sy = y[2:0]; s.found = f; s.last = l;
    path_due.push_back(s);
  endtask

  // a* over the mirrored wall map; expected words go into path_due
  task automatic plan_path(input cmd_word_t c);
    int w, h, start, goal, best, bx, by, nx, ny, nc, n, cx, cy;
    int unsigned bf, f, ng, hx, hy;
    int trail [$];
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    if (c.cx >= w || c.cy >= h || c.gx >= w || c.gy >= h) begin
      push_step(0, 0, 0, 1);
      return;
    end
    start = c.cy * 8 + c.cx;
    goal  = c.gy * 8 + c.gx;
    foreach (open_q[i]) begin
      open_q[i] = 0; shut_q[i] = 0;
    end
    open_q[start] = 1;
    cost_q[start] = 0;
    for (int it = 0; it <= Cells; it++) begin
      best = -1; bf = 0; bx = 0; by = 0;
      for (int y = 0; y < h; y++)
        for (int x = 0; x < w; x++)
          if (open_q[y*8+x]) begin
            hx = (x > c.gx) ? x - c.gx : c.gx - x;
            hy = (y > c.gy) ? y - c.gy : c.gy - y;
            f = cost_q[y*8+x] + (hx + hy) * 1000;
            if (best < 0 || f < bf) begin
              best = y*8+x; bf = f; bx = x; by = y;
            end
          end
      if (best < 0) break;
      open_q[best] = 0;
      if (best == goal) begin
        trail = {};
        trail.push_front(best);
        cx = bx; cy = by;
        while (cy*8+cx != start && trail.size() < Cells) begin
          n = via_q[cy*8+cx];
          cx -= step_dx(n); cy -= step_dy(n);
          if (cx < 0 || cy < 0 || cx >= w || cy >= h) break;
          trail.push_front(cy*8+cx);
        end
        foreach (trail[k])
          push_step(trail[k] % 8, trail[k] / 8, 1, k == trail.size() - 1);
        return;
      end
      shut_q[best] = 1;
      for (int d = 0; d < 8; d++) begin
        nx = bx + step_dx(d); ny = by + step_dy(d);
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        nc = ny*8 + nx;
        if (wall_q[nc] || shut_q[nc]) continue;
        ng = (cost_q[best] + ((step_dx(d) != 0 && step_dy(d) != 0) ? 1414 : 1000))
             & 17'h1ffff;
        if (!open_q[nc] || ng < cost_q[nc]) begin
          open_q[nc] = 1; cost_q[nc] = ng; via_q[nc] = d;
        end
      end
    end
    push_step(0, 0, 0, 1);
  endtask

  task automatic predict(input cmd_word_t c);
    if (c.func == FuncSetWall || c.func == FuncClearCell) begin
      if (c.cx < clamp_dim(width_reg) && c.cy < clamp_dim(height_reg))
        wall_q[c.cy*8+c.cx] = (c.func == FuncSetWall);
    end else if (c.func == FuncFindPath) begin
      plan_path(c);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    mismatches++;
  endtask

  // driver: presents the oldest pending command until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (!tx_paused && pending_cmds.size() > 0) begin
        if (!quiet_mode && $urandom_range(0, 7) == 0) begin
          tx_gap = $urandom_range(1, 10);
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          {func_i, cell_x_i, cell_y_i, goal_x_i, goal_y_i} <= pending_cmds[0];
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver readiness
  always @(negedge clk_i) begin
    if (hold_rx > 0) begin
      hold_rx--;
      out_ready_i <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 10);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor: predicts on acceptance, compares each path word with the oldest prediction
  always @(posedge clk_i) begin
    step_word_t want;
    cycle_cnt++;
    if (cycle_cnt > LimitCycles) begin
      $display("grid_astar_path_finder_top verification failed");
      $finish;
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      predict(pending_cmds.pop_front());
      in_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (path_due.size() == 0) report_mismatch("unexpected word", 1, 0);
      else begin
        want = path_due.pop_front();
        if (step_x_o !== want.sx) report_mismatch("step_x", step_x_o, want.sx);
        if (step_y_o !== want.sy) report_mismatch("step_y", step_y_o, want.sy);
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  function automatic cmd_word_t mk(input logic [1:0] f, input int x, input int y,
                                   input int gx, input int gy);
    mk = {f, x[2:0], y[2:0], gx[2:0], gy[2:0]};
  endfunction

  function automatic cmd_word_t rand_cmd();
    cmd_word_t c;
    c = 14'($urandom);
    // mostly searches and wall edits, a few unknown funcs
    case ($urandom_range(0, 9))
      0, 1, 2: c.func = FuncSetWall;
      3:       c.func = FuncClearCell;
      9:       c.func = FuncUnused;
      default: c.func = FuncFindPath;
    endcase
    return c;
  endfunction

  // wait until the block has drained and settled
  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid_i || path_due.size() > 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v[3:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxWidth) width_reg = v[3:0];
    else height_reg = v[3:0];
  endtask

  initial begin
    width_reg = 8; height_reg = 8;
    foreach (wall_q[i]) begin
      wall_q[i] = 0; cost_q[i] = 0; via_q[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: corners, trivial search, walls, blocked goal, detour, diagonals
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 7, 7));
    pending_cmds.push_back(mk(FuncFindPath, 7, 7, 0, 0));
    pending_cmds.push_back(mk(FuncFindPath, 3, 3, 3, 3));
    pending_cmds.push_back(mk(FuncSetWall, 3, 3, 0, 0));
    pending_cmds.push_back(mk(FuncFindPath, 3, 3, 3, 3));
    pending_cmds.push_back(mk(FuncFindPath, 3, 3, 5, 2));
    pending_cmds.push_back(mk(FuncFindPath, 0, 3, 3, 3));
    for (int y = 0; y < 8; y++) pending_cmds.push_back(mk(FuncSetWall, 4, y, 7, 7));
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 7, 0));
    pending_cmds.push_back(mk(FuncUnused, 7, 7, 7, 7));
    pending_cmds.push_back(mk(FuncClearCell, 4, 7, 0, 0));
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 7, 0));
    pending_cmds.push_back(mk(FuncFindPath, 6, 1, 1, 6));
    drain();

    // small grid, out-of-grid writes and searches
    write_cfg(CfgIdxWidth, 3);
    write_cfg(CfgIdxHeight, 2);
    pending_cmds.push_back(mk(FuncSetWall, 5, 5, 0, 0));
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 5, 1));
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 2, 1));
    pending_cmds.push_back(mk(FuncFindPath, 2, 0, 0, 1));
    drain();

    // zero acts as one, fifteen as the maximum
    write_cfg(CfgIdxWidth, 0);
    write_cfg(CfgIdxHeight, 15);
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 0, 7));
    pending_cmds.push_back(mk(FuncFindPath, 0, 0, 1, 0));
    drain();

    // clear the walls, full grid, then receiver hold-off so the block backs up
    write_cfg(CfgIdxWidth, 8);
    write_cfg(CfgIdxHeight, 8);
    pending_cmds.push_back(mk(FuncClearCell, 3, 3, 0, 0));
    for (int i = 0; i < 7; i++) pending_cmds.push_back(mk(FuncClearCell, 4, i, 0, 0));
    hold_rx = 3000;
    for (int i = 0; i < 8; i++) pending_cmds.push_back(mk(FuncFindPath, 0, i, 7, 7 - i));
    drain();

    // sender pauses until everything has come back
    for (int i = 0; i < 20; i++) pending_cmds.push_back(rand_cmd());
    while (pending_cmds.size() > 0) @(posedge clk_i);
    tx_paused = 1'b1;
    while (in_valid_i || path_due.size() > 0) @(posedge clk_i);
    tx_paused = 1'b0;
    drain();

    write_cfg(CfgIdxWidth, $urandom_range(1, 8));
    write_cfg(CfgIdxHeight, $urandom_range(1, 8));
    for (int i = 0; i < 35; i++) pending_cmds.push_back(rand_cmd());
    drain();

    // last part: no idling on either side
    write_cfg(CfgIdxWidth, 8);
    write_cfg(CfgIdxHeight, 8);
    quiet_mode = 1'b1;
    for (int i = 0; i < 25; i++) pending_cmds.push_back(rand_cmd());
    drain();

    if (mismatches == 0) $display("grid_astar_path_finder_top verification clean");
    else $display("grid_astar_path_finder_top verification failed");
    $finish;
  end

endmodule
